[rtl/core/msr_pkg.sv]
// Shared types and constants for the modular square root block.
`default_nettype none
package msr_pkg;

  // Candidates tried in the non-residue search
  localparam int unsigned NR_SEARCH = 4096;
  localparam int unsigned NR_CNT_W  = 13;

  // Sequencer states, one-hot
  typedef enum logic [21:0] {
    S_IDLE = 22'h000001,
    S_RED  = 22'h000002,
    S_EUL  = 22'h000004,
    S_SPL  = 22'h000008,
    S_NRC  = 22'h000010,
    S_NRT  = 22'h000020,
    S_B    = 22'h000040,
    S_BD   = 22'h000080,
    S_AI   = 22'h000100,
    S_X    = 22'h000200,
    S_LP   = 22'h000400,
    S_Z1   = 22'h000800,
    S_Z2   = 22'h001000,
    S_ZK   = 22'h002000,
    S_ZS   = 22'h004000,
    S_XU   = 22'h008000,
    S_CU   = 22'h010000,
    S_OUT  = 22'h020000,
    S_MUL  = 22'h040000,
    S_PW   = 22'h080000,
    S_PWM  = 22'h100000,
    S_PWS  = 22'h200000
  } msr_state_t;

endpackage
`default_nettype wire

[rtl/core/modular_square_root_top.sv]
// Tonelli-Shanks modular square root: sequencer around a shared multiplier.
// Work per item: several exponentiations of up to WIDTH squarings each,
// the non-residue search up to 4096 of them, plus up to t*t multiplies
// in the level loop.
// Throughput: one item at a time; input is stalled until the result is taken.
// Reset (rst_n, synchronous): sequencer idle, modulus returns to 3.
`default_nettype none
module modular_square_root_top
  import msr_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [WIDTH-1:0] cfg_modulus,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_operand,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [WIDTH-1:0]      out_root,
  output logic                  out_no_root
);

  localparam int unsigned TW = $clog2(WIDTH + 1) + 1;

  msr_state_t st_r, mret_r, pret_r;

  logic [WIDTH-1:0] p_r, a_r, s_r, n_r, c_r, ainv_r, x_r, z_r, b_r;
  logic [WIDTH-1:0] pb_r, pe_r, pr_r, mx_r, my_r;
  logic [WIDTH-1:0] root_r;
  logic             nr_r, mgo_r;
  logic [TW-1:0]    t_r, i_r, k_r;
  logic [NR_CNT_W-1:0] cnt_r;
  logic             mdone;
  logic [WIDTH-1:0] mq, pm1, half;

  assign pm1  = p_r - WIDTH'(1);
  assign half = pm1 >> 1;

  msr_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mgo_r),
    .x    (mx_r),
    .y    (my_r),
    .m    (p_r),
    .done (mdone),
    .q    (mq)
  );

  assign in_stall    = (st_r != S_IDLE);
  assign out_valid   = (st_r == S_OUT);
  assign out_root    = root_r;
  assign out_no_root = nr_r;

  // Modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= WIDTH'(3);
    end else if (cfg_we) begin
      p_r <= cfg_modulus;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      mret_r <= S_IDLE;
      pret_r <= S_IDLE;
      mgo_r  <= 1'b0;
    end else begin
      mgo_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            a_r <= in_operand;
            if (p_r < WIDTH'(3) || !p_r[0]) begin
              root_r <= '0;
              nr_r   <= 1'b1;
              st_r   <= S_OUT;
            end else begin
              // reduce a mod p as 1 * a
              mx_r <= WIDTH'(1); my_r <= in_operand; mgo_r <= 1'b1;
              mret_r <= S_RED; st_r <= S_MUL;
            end
          end
        end
        S_RED: begin
          a_r <= mq;
          if (mq == '0) begin
            root_r <= '0; nr_r <= 1'b0; st_r <= S_OUT;
          end else begin
            pb_r <= mq; pe_r <= half; pr_r <= WIDTH'(1);
            pret_r <= S_EUL; st_r <= S_PW;
          end
        end
        S_EUL: begin
          if (pr_r == pm1) begin
            root_r <= '0; nr_r <= 1'b1; st_r <= S_OUT;
          end else begin
            s_r <= pm1; t_r <= '0; st_r <= S_SPL;
          end
        end
        S_SPL: begin
          if (!s_r[0]) begin
            s_r <= s_r >> 1;
            t_r <= t_r + TW'(1);
          end else begin
            n_r <= pm1; c_r <= WIDTH'(2); cnt_r <= '0;
            st_r <= (t_r >= TW'(2)) ? S_NRC : S_B;
          end
        end
        S_NRC: begin
          if ((32'(cnt_r) < NR_SEARCH) && (c_r < pm1)) begin
            pb_r <= c_r; pe_r <= half; pr_r <= WIDTH'(1);
            pret_r <= S_NRT; st_r <= S_PW;
          end else begin
            st_r <= S_B;
          end
        end
        S_NRT: begin
          if (pr_r == pm1) begin
            n_r <= c_r; st_r <= S_B;
          end else begin
            c_r <= c_r + WIDTH'(1); cnt_r <= cnt_r + NR_CNT_W'(1); st_r <= S_NRC;
          end
        end
        S_B: begin
          pb_r <= n_r; pe_r <= s_r; pr_r <= WIDTH'(1);
          pret_r <= S_BD; st_r <= S_PW;
        end
        S_BD: begin
          b_r <= pr_r;
          pb_r <= a_r; pe_r <= p_r - WIDTH'(2); pr_r <= WIDTH'(1);
          pret_r <= S_AI; st_r <= S_PW;
        end
        S_AI: begin
          ainv_r <= pr_r;
          pb_r <= a_r; pe_r <= (s_r >> 1) + WIDTH'(1); pr_r <= WIDTH'(1);
          pret_r <= S_X; st_r <= S_PW;
        end
        S_X: begin
          x_r <= pr_r; i_r <= '0; st_r <= S_LP;
        end
        // Level loop: test and correct x once per level
        S_LP: begin
          if (i_r + TW'(1) < t_r) begin
            mx_r <= x_r; my_r <= x_r; mgo_r <= 1'b1;
            mret_r <= S_Z1; st_r <= S_MUL;
          end else begin
            root_r <= x_r; nr_r <= 1'b0; st_r <= S_OUT;
          end
        end
        S_Z1: begin
          mx_r <= ainv_r; my_r <= mq; mgo_r <= 1'b1;
          mret_r <= S_Z2; st_r <= S_MUL;
        end
        S_Z2: begin
          z_r <= mq; k_r <= '0; st_r <= S_ZK;
        end
        S_ZK: begin
          if (k_r + TW'(2) + i_r < t_r) begin
            mx_r <= z_r; my_r <= z_r; mret_r <= S_ZS;
          end else if (z_r == pm1) begin
            mx_r <= x_r; my_r <= b_r; mret_r <= S_XU;
          end else begin
            mx_r <= b_r; my_r <= b_r; mret_r <= S_CU;
          end
          mgo_r <= 1'b1; st_r <= S_MUL;
        end
        S_ZS: begin
          z_r <= mq; k_r <= k_r + TW'(1); st_r <= S_ZK;
        end
        S_XU: begin
          x_r <= mq;
          mx_r <= b_r; my_r <= b_r; mgo_r <= 1'b1;
          mret_r <= S_CU; st_r <= S_MUL;
        end
        S_CU: begin
          b_r <= mq; i_r <= i_r + TW'(1); st_r <= S_LP;
        end
        S_OUT: begin
          if (!out_stall) begin
            st_r <= S_IDLE;
          end
        end
        // Wait for the shared multiplier
        S_MUL: begin
          if (mdone) begin
            st_r <= mret_r;
          end
        end
        // Square-and-multiply exponentiation
        S_PW: begin
          if (pe_r == '0) begin
            st_r <= pret_r;
          end else if (pe_r[0]) begin
            mx_r <= pr_r; my_r <= pb_r; mgo_r <= 1'b1;
            mret_r <= S_PWM; st_r <= S_MUL;
          end else begin
            mx_r <= pb_r; my_r <= pb_r; mgo_r <= 1'b1;
            mret_r <= S_PWS; st_r <= S_MUL;
          end
        end
        S_PWM: begin
          pr_r <= mq;
          mx_r <= pb_r; my_r <= pb_r; mgo_r <= 1'b1;
          mret_r <= S_PWS; st_r <= S_MUL;
        end
        S_PWS: begin
          pb_r <= mq; pe_r <= pe_r >> 1; st_r <= S_PW;
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_nr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_root) |-> (out_root == '0)) else $error("root set with no-root flag");
  a_go_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mgo_r |-> (st_r == S_MUL)) else $error("multiply launched outside wait state");
`endif

endmodule
`default_nettype wire

[rtl/core/msr_mulmod.sv]
// Bit-serial modular multiplier: shift-and-add with reduction by the modulus.
`default_nettype none
module msr_mulmod #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic [WIDTH-1:0] m,
  output logic                  done,
  output logic [WIDTH-1:0]      q
);

  logic             run_r;
  logic [WIDTH-1:0] x_r, y_r, acc_r;
  logic [WIDTH-1:0] acc_sum, x_dbl;

  // Add two residues below m without overflow
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] md);
    logic [WIDTH-1:0] gap;
    gap = md - b;
    return (a >= gap) ? (a - gap) : (a + b);
  endfunction

  assign acc_sum = add_mod(acc_r, x_r, m);
  assign x_dbl   = add_mod(x_r, x_r, m);
  assign done    = run_r && (y_r == '0);
  assign q       = acc_r;

  // Control: run until the multiplier bits are used up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (go) begin
      run_r <= 1'b1;
    end else if (done) begin
      run_r <= 1'b0;
    end
  end

  // Datapath: one multiplier bit a cycle, least significant first
  always_ff @(posedge clk) begin
    if (go) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (run_r && (y_r != '0)) begin
      if (y_r[0]) begin
        acc_r <= acc_sum;
      end
      x_r <= x_dbl;
      y_r <= y_r >> 1;
    end
  end

`ifndef ASSERT_OFF
  a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !go) else $error("multiplier restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held for more than a cycle");
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!run_r && !go) |=> $stable(acc_r)) else $error("product moved while idle");
`endif

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the modular square root block: directed and random operands.
`timescale 1ns / 1ps
module tb_top;
  import msr_pkg::*;

  localparam int unsigned W = 32;

  typedef struct packed {
    logic [W-1:0] root;
    logic         no_root;
  } sqrt_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [W-1:0] cfg_modulus = '0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_operand = '0;
  logic         out_valid;
  logic         out_stall = 1'b1;
  logic [W-1:0] out_root;
  logic         out_no_root;

  // Predictor copy of the modulus register
  logic [W-1:0] cur_modulus = W'(3);
  logic [W-1:0] operand_q[$];
  sqrt_res_t    root_exp_q[$];
  int unsigned  send_idle_pct = 25;
  int unsigned  recv_stall_pct = 88;
  int unsigned  fail_cnt = 0;

  modular_square_root_top #(.WIDTH(W)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_modulus (cfg_modulus),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operand  (in_operand),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_root    (out_root),
    .out_no_root (out_no_root)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned addmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    if (x >= m - y) return x - (m - y);
    return x + y;
  endfunction

  function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    longint unsigned r;
    r = 0;
    x = x % m;
    while (y != 0) begin
      if (y[0]) r = addmod(r, x, m);
      x = addmod(x, x, m);
      y = y >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mulmod(r, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // Tonelli-Shanks on the current modulus
  function automatic sqrt_res_t modsqrt_predict(logic [W-1:0] operand, logic [W-1:0] modv);
    sqrt_res_t       res;
    longint unsigned p, a, pm1, half, s, n, b, ainv, x, c, z;
    int unsigned     t, cnt;
    bit              found;
    res = '0;
    p = modv;
    if (p < 3 || !p[0]) begin
      res.no_root = 1'b1;
      return res;
    end
    a = longint'(operand) % p;
    if (a == 0) return res;
    pm1 = p - 1;
    half = pm1 >> 1;
    if (powmod(a, half, p) == pm1) begin
      res.no_root = 1'b1;
      return res;
    end
    s = pm1;
    t = 0;
    while (!s[0]) begin
      s = s >> 1;
      t++;
    end
    n = pm1;
    if (t >= 2) begin
      found = 0;
      c = 2;
      for (cnt = 0; cnt < NR_SEARCH && c < pm1; cnt++) begin
        if (powmod(c, half, p) == pm1) begin
          found = 1;
          break;
        end
        c++;
      end
      if (found) n = c;
    end
    b = powmod(n, s, p);
    ainv = powmod(a, p - 2, p);
    x = powmod(a, (s >> 1) + 1, p);
    c = b;
    for (int unsigned i = 0; i + 1 < t; i++) begin
      z = mulmod(ainv, mulmod(x, x, p), p);
      for (int unsigned k = 0; k + 2 + i < t; k++) z = mulmod(z, z, p);
      if (z == pm1) x = mulmod(x, c, p);
      c = mulmod(c, c, p);
    end
    res.root = x[W-1:0];
    return res;
  endfunction

  // Driver: hold a beat until taken, then present the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        root_exp_q.push_back(modsqrt_predict(in_operand, cur_modulus));
      if (!in_valid || !in_stall) begin
        if (operand_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_operand <= operand_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each taken beat with the oldest expectation
  always @(posedge clk) begin
    sqrt_res_t want;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (root_exp_q.size() == 0) begin
        $display("%0t: unexpected result root=%0d no_root=%0b", $time, out_root, out_no_root);
        fail_cnt++;
      end else begin
        want = root_exp_q.pop_front();
        if (want.root !== out_root) begin
          $display("%0t: root expected %0d actual %0d", $time, want.root, out_root);
          fail_cnt++;
        end
        if (want.no_root !== out_no_root) begin
          $display("%0t: no_root expected %0b actual %0b", $time, want.no_root, out_no_root);
          fail_cnt++;
        end
      end
    end
  end

  function automatic bit block_busy();
    return operand_q.size() != 0 || in_valid || root_exp_q.size() != 0;
  endfunction

  // Drain, let the sequencer settle, then write the modulus
  task automatic set_modulus(logic [W-1:0] value);
    while (block_busy()) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_modulus <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_modulus = value;
  endtask

  // Random operand: full range, small, a known square, or a multiple of p
  function automatic logic [W-1:0] pick_operand(logic [W-1:0] modv);
    longint unsigned r;
    if (modv < 3) return $urandom;
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(40);
      2: begin
        r = $urandom;
        return W'(mulmod(r, r, modv));
      end
      default: return W'(longint'(modv) * $urandom_range(3));
    endcase
  endfunction

  localparam logic [W-1:0] MOD_POOL[16] = '{
    32'd3, 32'd5, 32'd7, 32'd13, 32'd17, 32'd41, 32'd97, 32'd257, 32'd65537,
    32'd4294967291, 32'd4294967295, 32'd9, 32'd15, 32'd0, 32'd2, 32'd3221225473
  };

  initial begin
    logic [W-1:0] m;
    int unsigned  done_cnt, seg;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset modulus of 3, then the extremes of the operand
    operand_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFFFFFF};
    // Level loop with t = 4
    set_modulus(32'd17);
    operand_q = '{32'd2, 32'd4, 32'd13, 32'd16, 32'd3, 32'd17, 32'hFFFFFFFF};
    // Invalid moduli: even, and below three
    set_modulus(32'd0);
    operand_q = '{32'd5};
    set_modulus(32'd2);
    operand_q = '{32'd0};
    set_modulus(32'd4);
    operand_q = '{32'd9};
    // Largest modulus (composite) and largest prime
    set_modulus(32'hFFFFFFFF);
    operand_q = '{32'd4, 32'hFFFFFFFE};
    set_modulus(32'd4294967291);
    operand_q = '{32'd7, 32'hAAAAAAAA};
    // Deep level loop, t = 30
    set_modulus(32'd3221225473);
    operand_q = '{32'd25, 32'h55555555};
    // Composite with a short non-residue search
    set_modulus(32'd9);
    operand_q = '{32'd7};

    done_cnt = 0;
    while (done_cnt < 118) begin
      if (done_cnt >= 75) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else if (done_cnt >= 32) begin
        send_idle_pct = 88;
        recv_stall_pct = 25;
      end
      m = MOD_POOL[$urandom_range(15)];
      set_modulus(m);
      seg = (m == 32'd3221225473) ? 3 : 10;
      repeat (seg) operand_q.push_back(pick_operand(m));
      done_cnt += seg;
    end

    while (block_busy()) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #400_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
